>>> rtl/spiral_order_matrix_reader_core_defines.svh
// Assertion macros shared by the spiral order matrix reader checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SPIRAL_ORDER_MATRIX_READER_CORE_DEFINES_SVH
`define SPIRAL_ORDER_MATRIX_READER_CORE_DEFINES_SVH

// Property checked on every rising clock edge, quiet while reset is asserted
`define SOMR_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("somr assertion failed");

// Condition that must never hold while out of reset
`define SOMR_ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("somr forbidden condition seen");

`endif

>>> rtl/somr_pkg.sv
// Package for the spiral order matrix reader: sizes, register indexes,
// state and direction types, count clamping. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package somr_pkg;

  // Matrix and word sizes
  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLUMNS = 8;
  localparam int VALUE_WIDTH = 16;
  localparam int COUNT_W     = 4;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int POS_W       = 7;

  // Configuration register indexes
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_SHOW
  } somr_state_e;

  // Walk direction around the current ring
  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } somr_dir_e;

  // Zero acts as one, anything above the maximum saturates
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input int maxv);
    logic [COUNT_W-1:0] res;
    if (v == '0) begin
      res = COUNT_W'(1);
    end else if (int'(v) > maxv) begin
      res = COUNT_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/spiral_order_matrix_reader_core.sv
// Loading accepts words while in the load state; the first result word is shown once the
// word that completes the matrix is accepted and the read state has done one store read.
// Each result word is read from the store in the read state, then held in the output
// register until the sink takes it; the next word is read only after that.
// Reset clears the sequencer, load position and counts (to 1); the store is not.
`timescale 1ns / 1ps
`default_nettype none

module spiral_order_matrix_reader_core
  import somr_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [COUNT_W-1:0]            cfg_data_i,
  // element input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0] element_value_i,
  // spiral output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0]      spiral_value_o,
  output logic                               last_of_run_o
);

  // Configuration registers
  logic [COUNT_W-1:0] row_count_q, column_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= COUNT_W'(1);
      column_count_q <= COUNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Effective counts and element total
  logic [COUNT_W-1:0]   rows_eff, cols_eff, rows_m1, cols_m1;
  logic [2*COUNT_W-1:0] total_full;
  logic [POS_W-1:0]     total, total_m1;

  assign rows_eff   = clamp_count(row_count_q, MAX_ROWS);
  assign cols_eff   = clamp_count(column_count_q, MAX_COLUMNS);
  assign rows_m1    = rows_eff - COUNT_W'(1);
  assign cols_m1    = cols_eff - COUNT_W'(1);
  assign total_full = {{COUNT_W{1'b0}}, rows_eff} * {{COUNT_W{1'b0}}, cols_eff};
  assign total      = total_full[POS_W-1:0];
  assign total_m1   = total - POS_W'(1);

  // Sequencer and walker registers
  somr_state_e       state_q, state_d;
  somr_dir_e         dir_q, dir_d;
  logic [ROW_W-1:0]  row_q, row_d, top_q, top_d, bottom_q, bottom_d;
  logic [COL_W-1:0]  col_q, col_d, left_q, left_d, right_q, right_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [POS_W-1:0]  load_pos_q, load_pos_inc;
  logic [POS_W-1:0]  emit_cnt_q;
  logic              last_q;
  logic signed [VALUE_WIDTH-1:0] value_q;

  logic in_fire, out_fire, load_done;

  assign in_fire      = in_valid_i && in_ready_o;
  assign out_fire     = out_valid_o && out_ready_i;
  assign load_pos_inc = load_pos_q + POS_W'(1);
  assign load_done    = (load_pos_inc >= total);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: if (in_fire && load_done) state_d = S_READ;
      S_READ: state_d = S_SHOW;
      S_SHOW: begin
        if (out_fire) state_d = last_q ? S_LOAD : S_READ;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD:  in_ready_o  = 1'b1;
      S_READ:  ;
      S_SHOW:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Walker step: pick the next ring position; one shared adder moves the
  // store address by +1, +columns, -1 or -columns
  logic [ADDR_W-1:0] step;
  logic [ROW_W:0]    top_p1;

  assign top_p1 = {1'b0, top_q} + (ROW_W+1)'(1);

  always_comb begin
    dir_d    = dir_q;
    row_d    = row_q;
    col_d    = col_q;
    top_d    = top_q;
    bottom_d = bottom_q;
    left_d   = left_q;
    right_d  = right_q;
    case (dir_q)
      DIR_RIGHT: begin
        if (col_q < right_q) begin
          col_d = col_q + COL_W'(1);
        end else begin
          dir_d = DIR_DOWN;
          row_d = row_q + ROW_W'(1);
        end
      end
      DIR_DOWN: begin
        if (row_q < bottom_q) begin
          row_d = row_q + ROW_W'(1);
        end else begin
          dir_d = DIR_LEFT;
          col_d = col_q - COL_W'(1);
        end
      end
      DIR_LEFT: begin
        if (col_q > left_q) begin
          col_d = col_q - COL_W'(1);
        end else begin
          dir_d = DIR_UP;
          row_d = row_q - ROW_W'(1);
        end
      end
      default: begin
        if ({1'b0, row_q} != top_p1) begin
          row_d = row_q - ROW_W'(1);
        end else begin
          // ring finished: shrink bounds, step right into the next ring
          dir_d    = DIR_RIGHT;
          col_d    = col_q + COL_W'(1);
          top_d    = top_q + ROW_W'(1);
          bottom_d = bottom_q - ROW_W'(1);
          left_d   = left_q + COL_W'(1);
          right_d  = right_q - COL_W'(1);
        end
      end
    endcase

    case (dir_d)
      DIR_RIGHT: step = ADDR_W'(1);
      DIR_DOWN:  step = ADDR_W'(cols_eff);
      DIR_LEFT:  step = {ADDR_W{1'b1}};
      default:   step = ADDR_W'(0) - ADDR_W'(cols_eff);
    endcase
    addr_d = addr_q + step;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_pos_q <= '0;
      emit_cnt_q <= '0;
      dir_q      <= DIR_RIGHT;
      row_q      <= '0;
      col_q      <= '0;
      top_q      <= '0;
      bottom_q   <= '0;
      left_q     <= '0;
      right_q    <= '0;
      addr_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (load_done) begin
          // matrix complete: start the walk at the top-left corner
          load_pos_q <= '0;
          emit_cnt_q <= '0;
          dir_q      <= DIR_RIGHT;
          row_q      <= '0;
          col_q      <= '0;
          top_q      <= '0;
          left_q     <= '0;
          bottom_q   <= rows_m1[ROW_W-1:0];
          right_q    <= cols_m1[COL_W-1:0];
          addr_q     <= '0;
        end else begin
          load_pos_q <= load_pos_inc;
        end
      end
      if (state_q == S_READ) begin
        last_q <= (emit_cnt_q == total_m1);
      end
      if (out_fire && !last_q) begin
        emit_cnt_q <= emit_cnt_q + POS_W'(1);
        dir_q      <= dir_d;
        row_q      <= row_d;
        col_q      <= col_d;
        top_q      <= top_d;
        bottom_q   <= bottom_d;
        left_q     <= left_d;
        right_q    <= right_d;
        addr_q     <= addr_d;
      end
    end
  end

  // Matrix store: one write port for loading, one registered read port
  logic [VALUE_WIDTH-1:0] store_q [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      store_q[load_pos_q[ADDR_W-1:0]] <= element_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      value_q <= store_q[addr_q];
    end
  end

  assign spiral_value_o = value_q;
  assign last_of_run_o  = last_q;

endmodule

`default_nettype wire

>>> rtl/somr_checker.sv
// Port-level checker for the spiral order matrix reader, bound to the top level.
// Depends on somr_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "spiral_order_matrix_reader_core_defines.svh"

module somr_checker
  import somr_pkg::*;
(
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [VALUE_WIDTH-1:0] spiral_value_o,
  input wire logic                          last_of_run_o
);

  // Loading and emitting never overlap
  `SOMR_ASSERT_NEVER(a_load_emit_excl, clk_i, rst_ni, in_ready_o && out_valid_o)

  // Final word of a run hands back to loading
  `SOMR_ASSERT(a_last_to_load, clk_i, rst_ni,
    (out_valid_o && out_ready_i && last_of_run_o) |=> in_ready_o)

  // Mid-run words keep the input closed
  `SOMR_ASSERT(a_mid_run_closed, clk_i, rst_ni,
    (out_valid_o && out_ready_i && !last_of_run_o) |=> !in_ready_o)

  // A stalled output word holds
  `SOMR_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(spiral_value_o) && $stable(last_of_run_o)))

endmodule

bind spiral_order_matrix_reader_core somr_checker u_somr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .spiral_value_o (spiral_value_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire
